[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that two conditions are never true in the same cycle.
`define ASSERT_NEVER(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !((a) && (b))) else $error(msg);

`endif

[hw/rtl/apa_pkg.sv]
// ----------------------------------------------------------------------------
// apa_pkg
// Types and constants shared by the APA102 chain frame driver.
// ----------------------------------------------------------------------------
package apa_pkg;

    // chain size
    localparam int NUM_LEDS  = 3;
    localparam int NUM_BYTES = 8 + 4 * NUM_LEDS;
    localparam int BYTE_W    = $clog2(NUM_BYTES);
    localparam int LED_W     = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int FRAME_END = 4 + 4 * NUM_LEDS;

    // command codes
    localparam logic [1:0] MODE_SET   = 2'd0;
    localparam logic [1:0] MODE_WHEEL = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // stream bytes
    localparam logic [7:0] BYTE_START = 8'h00;
    localparam logic [7:0] BYTE_END   = 8'hFF;
    localparam logic [7:0] HDR_ON     = 8'hFF;
    localparam logic [7:0] HDR_BLANK  = 8'hE0;

    // wheel segment bounds
    localparam logic [7:0] WHEEL_MAX  = 8'd255;
    localparam logic [7:0] WHEEL_SEG1 = 8'd85;
    localparam logic [7:0] WHEEL_SEG2 = 8'd170;

    // command word passed from front to back, color is red<<16|green<<8|blue
    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  sel;
        logic [23:0] color;
    } t_cmd;

    // queue status seen by the back end
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_state;

endpackage

[hw/rtl/apa_front.sv]
// ----------------------------------------------------------------------------
// apa_front
// Accepts commands, drops unused codes and resolves the wheel color.
// ----------------------------------------------------------------------------
module apa_front (
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_mode,
    input  logic [1:0]      i_led_select,
    input  logic [7:0]      i_red,
    input  logic [7:0]      i_green,
    input  logic [7:0]      i_blue,
    input  logic [7:0]      i_wheel_pos,
    input  apa_pkg::t_q_status i_q_status,
    output logic            o_push,
    output apa_pkg::t_cmd   o_cmd
);

    logic [7:0] p;
    logic [7:0] q;
    logic [9:0] q3;
    logic [7:0] up;
    logic [7:0] dn;
    logic [7:0] wr, wg, wb;

    // wheel color, three segments of 85, 85 and 86 steps
    always_comb begin
        p = ~i_wheel_pos;
        if (p < apa_pkg::WHEEL_SEG1) begin
            q = p;
        end else if (p < apa_pkg::WHEEL_SEG2) begin
            q = p - apa_pkg::WHEEL_SEG1;
        end else begin
            q = p - apa_pkg::WHEEL_SEG2;
        end
        q3 = {2'b00, q} + {1'b0, q, 1'b0};
        up = q3[7:0];
        dn = apa_pkg::WHEEL_MAX - q3[7:0];
        if (p < apa_pkg::WHEEL_SEG1) begin
            wr = dn;   wg = 8'd0; wb = up;
        end else if (p < apa_pkg::WHEEL_SEG2) begin
            wr = 8'd0; wg = up;   wb = dn;
        end else begin
            wr = up;   wg = dn;   wb = 8'd0;
        end
    end

    // classify and push; unused code is taken and dropped
    always_comb begin
        o_ready    = !i_q_status.full;
        o_push     = i_valid && o_ready && (i_mode != apa_pkg::MODE_NONE);
        o_cmd.mode = i_mode;
        o_cmd.sel  = i_led_select;
        if (i_mode == apa_pkg::MODE_WHEEL) begin
            o_cmd.color = {wr, wg, wb};
        end else begin
            o_cmd.color = {i_red, i_green, i_blue};
        end
    end

endmodule

[hw/rtl/apa_queue.sv]
// ----------------------------------------------------------------------------
// apa_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module apa_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  apa_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output apa_pkg::t_cmd      o_cmd,
    output apa_pkg::t_q_status o_status
);

    apa_pkg::t_cmd r_mem [2];
    logic          r_wr, r_rd;
    logic [1:0]    r_count;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

    assign o_cmd          = r_mem[r_rd];
    assign o_status.empty = (r_count == 2'd0);
    assign o_status.full  = (r_count == 2'd2);

endmodule

[hw/rtl/apa_back.sv]
// ----------------------------------------------------------------------------
// apa_back
// Holds the color store and sequences the byte stream of each command.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apa_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  apa_pkg::t_cmd      i_cmd,
    input  apa_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_last
);

    apa_pkg::t_state r_state, n_state;
    apa_pkg::t_cmd   r_cmd;
    logic [23:0]     r_store [apa_pkg::NUM_LEDS];
    logic [apa_pkg::BYTE_W-1:0] r_idx;
    logic            r_out_valid;
    logic [7:0]      r_byte;
    logic            r_last;

    logic            slot_free;
    logic            at_last;
    logic            emit;
    logic [apa_pkg::BYTE_W-1:0] k;
    logic [apa_pkg::LED_W-1:0]  led;
    logic [23:0]     color;
    logic [7:0]      n_byte;
    logic [apa_pkg::LED_W-1:0]  wr_idx;

    assign slot_free = !r_out_valid || i_ready;
    assign at_last   = (r_idx == apa_pkg::BYTE_W'(apa_pkg::NUM_BYTES - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            apa_pkg::ST_IDLE: begin
                if (!i_q_status.empty) n_state = apa_pkg::ST_SEND;
            end
            apa_pkg::ST_SEND: begin
                if (slot_free && at_last && i_q_status.empty) n_state = apa_pkg::ST_IDLE;
            end
            default: n_state = apa_pkg::ST_IDLE;
        endcase
    end

    // state outputs: pop a command at start or on the final byte
    always_comb begin
        o_pop = 1'b0;
        emit  = 1'b0;
        unique case (r_state)
            apa_pkg::ST_IDLE: begin
                o_pop = !i_q_status.empty;
            end
            apa_pkg::ST_SEND: begin
                emit  = slot_free;
                o_pop = slot_free && at_last && !i_q_status.empty;
            end
            default: begin
                o_pop = 1'b0;
                emit  = 1'b0;
            end
        endcase
    end

    // byte at the current position
    always_comb begin
        k     = r_idx - apa_pkg::BYTE_W'(4);
        led   = k[apa_pkg::LED_W+1:2];
        case (r_cmd.mode)
            apa_pkg::MODE_SET:   color = r_store[led];
            apa_pkg::MODE_WHEEL: color = r_cmd.color;
            default:             color = 24'd0;
        endcase
        if (r_idx < apa_pkg::BYTE_W'(4)) begin
            n_byte = apa_pkg::BYTE_START;
        end else if (r_idx >= apa_pkg::BYTE_W'(apa_pkg::FRAME_END)) begin
            n_byte = apa_pkg::BYTE_END;
        end else begin
            case (k[1:0])
                2'd0:    n_byte = (r_cmd.mode == apa_pkg::MODE_CLEAR) ?
                                  apa_pkg::HDR_BLANK : apa_pkg::HDR_ON;
                2'd1:    n_byte = color[7:0];
                2'd2:    n_byte = color[15:8];
                default: n_byte = color[23:16];
            endcase
        end
    end

    // sequencer registers; position wraps to zero after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= apa_pkg::ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_idx <= '0;
            end else if (emit) begin
                r_idx <= at_last ? '0 : r_idx + 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output word and current command
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= n_byte;
            r_last <= at_last;
        end
        if (o_pop) r_cmd <= i_cmd;
    end

    // color store, written when a set command with an in-range select starts
    assign wr_idx = apa_pkg::LED_W'(i_cmd.sel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < apa_pkg::NUM_LEDS; i++) r_store[i] <= 24'd0;
        end else if (o_pop && (i_cmd.mode == apa_pkg::MODE_SET) &&
                     ({3'b000, i_cmd.sel} < 5'(apa_pkg::NUM_LEDS))) begin
            r_store[wr_idx] <= i_cmd.color;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_byte;
    assign o_last     = r_last;

    // checks
    `ASSERT_CLK(a_last_is_end, i_clk, i_rst_n, (r_out_valid && r_last) |-> (r_byte == apa_pkg::BYTE_END), "last word is not an end byte")
    `ASSERT_CLK(a_idx_range, i_clk, i_rst_n, r_idx < apa_pkg::BYTE_W'(apa_pkg::NUM_BYTES), "byte position out of range")
    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, o_pop, i_q_status.empty, "pop from empty queue")

endmodule

[hw/rtl/apa102_led_chain_frame_driver.sv]
// ----------------------------------------------------------------------------
// apa102_led_chain_frame_driver
// APA102 chain driver: one command in, one full serial byte stream out.
// ----------------------------------------------------------------------------
// Each accepted command (set, wheel or clear) yields 8 + 4*NUM_LEDS output
// words, 20 for three LEDs: four 0x00 start bytes, one frame per LED, four
// 0xFF end bytes, with o_last on the final one. The back end sends one word
// per cycle while the output is not stalled; streams of queued commands follow
// one another with no gap. A two-entry command queue lets the input run ahead
// of the output by two commands. Mode 3 is accepted and produces nothing. The
// LED color store resets to black.
module apa102_led_chain_frame_driver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_mode,
    input  logic [1:0] i_led_select,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic [7:0] i_wheel_pos,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    logic               push;
    logic               pop;
    apa_pkg::t_cmd      f_cmd;
    apa_pkg::t_cmd      q_cmd;
    apa_pkg::t_q_status q_status;

    apa_front u_front (
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_led_select (i_led_select),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_wheel_pos  (i_wheel_pos),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_cmd        (f_cmd)
    );

    apa_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (f_cmd),
        .i_pop    (pop),
        .o_cmd    (q_cmd),
        .o_status (q_status)
    );

    apa_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (q_cmd),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

endmodule

[sim/apa102_led_chain_frame_driver_tb.sv]
// ----------------------------------------------------------------------------
// apa102_led_chain_frame_driver_tb
// Self-checking bench for the APA102 chain frame driver.
// ----------------------------------------------------------------------------
// Commands go in over a valid/ready channel, either back to back or with
// random gaps. Each accepted command is run through a local model of the
// chain: the color store, the wheel and the stream layout. The model queues
// the bytes that the command should produce. Every word taken from the output
// channel is checked against the oldest queued byte and its last flag. The
// output side stalls in random bursts. Both sides run clean for the final
// stretch of commands.
module apa102_led_chain_frame_driver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_CMDS   = 180;
    localparam int CALM_CMDS   = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_led_word;

    // Chain model: color store plus the queue of bytes still owed
    class t_stream_checker;
        logic [23:0] led_rgb [apa_pkg::NUM_LEDS];
        t_led_word   bytes_due [$];
        int          errors;

        function new();
            foreach (led_rgb[i]) led_rgb[i] = '0;
            errors = 0;
        endfunction

        // Rainbow in three segments, indexed from the top of the wheel
        function logic [23:0] wheel_rgb(logic [7:0] pos);
            int p;
            int r;
            int g;
            int b;
            p = int'(apa_pkg::WHEEL_MAX) - int'(pos);
            if (p < int'(apa_pkg::WHEEL_SEG1)) begin
                r = 255 - 3 * p;
                g = 0;
                b = 3 * p;
            end else if (p < int'(apa_pkg::WHEEL_SEG2)) begin
                p = p - int'(apa_pkg::WHEEL_SEG1);
                r = 0;
                g = 3 * p;
                b = 255 - 3 * p;
            end else begin
                p = p - int'(apa_pkg::WHEEL_SEG2);
                r = 3 * p;
                g = 255 - 3 * p;
                b = 0;
            end
            return {r[7:0], g[7:0], b[7:0]};
        endfunction

        function void push_byte(logic [7:0] data, logic last);
            t_led_word w;
            w.data = data;
            w.last = last;
            bytes_due.push_back(w);
        endfunction

        // Update the store and queue the full stream for one command
        function void take_command(logic [1:0] mode, logic [1:0] sel, logic [7:0] red,
                                   logic [7:0] green, logic [7:0] blue, logic [7:0] pos);
            logic [23:0] wheel;
            logic [23:0] rgb;
            logic [7:0]  hdr;
            if (mode == apa_pkg::MODE_NONE)
                return;
            if (mode == apa_pkg::MODE_SET && sel < apa_pkg::NUM_LEDS)
                led_rgb[sel] = {red, green, blue};
            wheel = wheel_rgb(pos);
            for (int i = 0; i < 4; i++)
                push_byte(apa_pkg::BYTE_START, 1'b0);
            for (int i = 0; i < apa_pkg::NUM_LEDS; i++) begin
                hdr = apa_pkg::HDR_ON;
                case (mode)
                    apa_pkg::MODE_SET: begin
                        rgb = led_rgb[i];
                    end
                    apa_pkg::MODE_WHEEL: begin
                        rgb = wheel;
                    end
                    default: begin
                        hdr = apa_pkg::HDR_BLANK;
                        rgb = '0;
                    end
                endcase
                push_byte(hdr, 1'b0);
                push_byte(rgb[7:0], 1'b0);
                push_byte(rgb[15:8], 1'b0);
                push_byte(rgb[23:16], 1'b0);
            end
            for (int i = 0; i < 4; i++)
                push_byte(apa_pkg::BYTE_END, i == 3);
        endfunction

        function void check_word(logic [7:0] data, logic last);
            t_led_word want;
            if (bytes_due.size() == 0) begin
                errors++;
                $display("%0t: word with nothing due, expected none, actual byte %02h last %0b",
                         $time, data, last);
                return;
            end
            want = bytes_due.pop_front();
            if (data !== want.data) begin
                errors++;
                $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                         $time, want.data, data);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: last mismatch, expected %0b, actual %0b",
                         $time, want.last, last);
            end
        endfunction

        function int pending();
            return bytes_due.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [1:0] i_mode;
    logic [1:0] i_led_select;
    logic [7:0] i_red;
    logic [7:0] i_green;
    logic [7:0] i_blue;
    logic [7:0] i_wheel_pos;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_byte;
    logic       o_last;

    t_stream_checker chain = new();
    int              cycles = 0;
    bit              calm = 1'b0;

    apa102_led_chain_frame_driver uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_led_select (i_led_select),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_wheel_pos  (i_wheel_pos),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Both handshakes are observed at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                chain.take_command(i_mode, i_led_select, i_red, i_green, i_blue, i_wheel_pos);
            if (o_valid && i_ready)
                chain.check_word(o_out_byte, o_last);
        end
    end

    // Output side: random stall bursts, some long clean runs
    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            if (!calm && $urandom_range(0, 29) == 0)
                repeat ($urandom_range(20, 60)) @(negedge i_clk);
        end
    end

    // Present one command from a falling edge and hold it until accepted
    task automatic send_cmd(input logic [1:0] mode, input logic [1:0] sel,
                            input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue, input logic [7:0] pos);
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_led_select <= sel;
        i_red        <= red;
        i_green      <= green;
        i_blue       <= blue;
        i_wheel_pos  <= pos;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
    endtask

    // Hold off new commands until every owed byte has come out
    task automatic drain_chain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (chain.pending() != 0) @(negedge i_clk);
    endtask

    initial begin
        int         sent;
        int         pick;
        logic [1:0] mode;
        logic [1:0] sel;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;

        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_mode       = apa_pkg::MODE_SET;
        i_led_select = '0;
        i_red        = '0;
        i_green      = '0;
        i_blue       = '0;
        i_wheel_pos  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: store extremes, out-of-range LED, wheel boundaries,
        // clear, the unused mode, fields that a mode ignores
        send_cmd(apa_pkg::MODE_SET,   2'd0, 8'hFF, 8'h00, 8'h00, 8'hFF);
        send_cmd(apa_pkg::MODE_SET,   2'd1, 8'h00, 8'hFF, 8'h00, 8'h00);
        send_cmd(apa_pkg::MODE_SET,   2'd2, 8'h00, 8'h00, 8'hFF, 8'hAA);
        send_cmd(apa_pkg::MODE_SET,   2'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(apa_pkg::MODE_SET,   2'd1, 8'hFF, 8'hFF, 8'hFF, 8'h55);
        send_cmd(apa_pkg::MODE_SET,   2'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(apa_pkg::MODE_WHEEL, 2'd3, 8'hFF, 8'hFF, 8'hFF, 8'd0);
        send_cmd(apa_pkg::MODE_WHEEL, 2'd0, 8'h00, 8'h00, 8'h00, 8'd84);
        send_cmd(apa_pkg::MODE_WHEEL, 2'd1, 8'h12, 8'h34, 8'h56, 8'd85);
        send_cmd(apa_pkg::MODE_WHEEL, 2'd2, 8'h00, 8'h00, 8'h00, 8'd86);
        send_cmd(apa_pkg::MODE_WHEEL, 2'd0, 8'h00, 8'h00, 8'h00, 8'd169);
        send_cmd(apa_pkg::MODE_WHEEL, 2'd0, 8'h00, 8'h00, 8'h00, 8'd170);
        send_cmd(apa_pkg::MODE_WHEEL, 2'd0, 8'h00, 8'h00, 8'h00, 8'd171);
        send_cmd(apa_pkg::MODE_WHEEL, 2'd0, 8'h00, 8'h00, 8'h00, 8'd255);
        send_cmd(apa_pkg::MODE_CLEAR, 2'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(apa_pkg::MODE_SET,   2'd2, 8'h5A, 8'hA5, 8'h3C, 8'h00);
        send_cmd(apa_pkg::MODE_NONE,  2'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(apa_pkg::MODE_NONE,  2'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(apa_pkg::MODE_SET,   2'd3, 8'h01, 8'h02, 8'h03, 8'h04);
        send_cmd(apa_pkg::MODE_CLEAR, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(apa_pkg::MODE_SET,   2'd1, 8'h80, 8'h01, 8'h7F, 8'hFE);
        drain_chain();

        // Random commands, unused-mode ones not counted
        sent = 0;
        while (sent < RAND_CMDS) begin
            pick = $urandom_range(0, 19);
            if (pick < 8)
                mode = apa_pkg::MODE_SET;
            else if (pick < 14)
                mode = apa_pkg::MODE_WHEEL;
            else if (pick < 18)
                mode = apa_pkg::MODE_CLEAR;
            else
                mode = apa_pkg::MODE_NONE;
            sel   = ($urandom_range(0, 9) == 0) ? 2'd3 :
                    2'($urandom_range(0, apa_pkg::NUM_LEDS - 1));
            red   = 8'($urandom_range(0, 255));
            green = 8'($urandom_range(0, 255));
            blue  = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0) begin
                red   = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                green = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                blue  = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            end
            if (sent == RAND_CMDS - CALM_CMDS)
                calm = 1'b1;
            send_cmd(mode, sel, red, green, blue, 8'($urandom_range(0, 255)));
            if (mode != apa_pkg::MODE_NONE)
                sent++;
            if (sent == RAND_CMDS / 2 && mode != apa_pkg::MODE_NONE)
                drain_chain();
        end
        i_valid <= 1'b0;

        while (chain.pending() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        if (chain.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/apa_pkg.sv
hw/rtl/apa_front.sv
hw/rtl/apa_queue.sv
hw/rtl/apa_back.sv
hw/rtl/apa102_led_chain_frame_driver.sv
sim/apa102_led_chain_frame_driver_tb.sv
